// ===== design/hmmp_pkg.sv =====
// Shared constants, types and helper functions of the hemisphere partition block.
package hmmp_pkg;

    // Event and datapath sizes
    localparam int MAX_JETS   = 16;
    localparam int COMP_WIDTH = 20;
    localparam int SUM_W      = COMP_WIDTH + $clog2(MAX_JETS);
    localparam int MET_W      = 2 * SUM_W + 3;
    localparam int CNT_W      = $clog2(MAX_JETS + 1);
    localparam int IDX_W      = $clog2(MAX_JETS);
    localparam int K_W        = MAX_JETS + 1;
    localparam int SQ_CNT_W   = 4;
    localparam int NUM_SQ     = 8;

    // Stream widths
    localparam int P_OUT_W    = 24;
    localparam int E_OUT_W    = 23;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 192;
    localparam int OUT_PAD_W  = OUT_DATA_W - 6 * P_OUT_W - 2 * E_OUT_W;
    localparam int STATUS_W   = 2;

    // Four-vector component selectors
    localparam logic [1:0] COMP_PX = 2'd0;
    localparam logic [1:0] COMP_PY = 2'd1;
    localparam logic [1:0] COMP_PZ = 2'd2;
    localparam logic [1:0] COMP_E  = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_FEW  = 2'd1,
        STATUS_TOO_MANY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SQ,
        S_CMP,
        S_UPD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] px;
        logic signed [COMP_WIDTH-1:0] py;
        logic signed [COMP_WIDTH-1:0] pz;
        logic        [COMP_WIDTH-2:0] energy;
    } t_jet;

    typedef struct packed {
        logic signed [SUM_W-1:0] px;
        logic signed [SUM_W-1:0] py;
        logic signed [SUM_W-1:0] pz;
        logic signed [SUM_W-1:0] energy;
    } t_vec;

    typedef struct packed {
        logic valid;
        logic clear;
        logic negate;
    } t_mac_ctl;

    // Widen a stored jet to sum width
    function automatic t_vec jet_to_vec(t_jet j);
        t_vec v;
        v.px     = SUM_W'(j.px);
        v.py     = SUM_W'(j.py);
        v.pz     = SUM_W'(j.pz);
        v.energy = SUM_W'(j.energy);
        return v;
    endfunction

    function automatic t_vec vec_add(t_vec a, t_vec b);
        t_vec v;
        v.px     = a.px + b.px;
        v.py     = a.py + b.py;
        v.pz     = a.pz + b.pz;
        v.energy = a.energy + b.energy;
        return v;
    endfunction

    function automatic t_vec vec_sub(t_vec a, t_vec b);
        t_vec v;
        v.px     = a.px - b.px;
        v.py     = a.py - b.py;
        v.pz     = a.pz - b.pz;
        v.energy = a.energy - b.energy;
        return v;
    endfunction

endpackage

// ===== design/hmmp_mac.sv =====
// Shared square-and-accumulate unit that builds the mass metric one component at a time.
module hmmp_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [hmmp_pkg::SUM_W-1:0] i_op,
    input  hmmp_pkg::t_mac_ctl                i_ctl,
    output logic signed [hmmp_pkg::MET_W-1:0] o_acc
);

    logic signed [2*hmmp_pkg::SUM_W-1:0] r_prod;
    hmmp_pkg::t_mac_ctl                  r_ctl;
    logic signed [hmmp_pkg::MET_W-1:0]   r_acc;
    logic signed [hmmp_pkg::MET_W-1:0]   prod_ext;
    logic signed [hmmp_pkg::MET_W-1:0]   term;
    logic signed [hmmp_pkg::MET_W-1:0]   base;
    logic signed [hmmp_pkg::MET_W-1:0]   n_acc;

    // Track which products are live
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Square the operand
    always_ff @(posedge i_clk) begin
        r_prod <= i_op * i_op;
    end

    // Add or subtract the registered square
    always_comb begin
        prod_ext = hmmp_pkg::MET_W'(r_prod);
        term     = r_ctl.negate ? -prod_ext : prod_ext;
        base     = r_ctl.clear ? '0 : r_acc;
        n_acc    = base + term;
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== design/hemisphere_min_mass_partition.sv =====
// Top level: jet loading, Gray-code partition search and result register.
// Jets stream in one per cycle while tready is high; tlast closes the event. Up to 16
// jets are kept, and extra jets are dropped and flag the event as too many. After the
// last jet the block walks all 2^n hemisphere assignments in Gray-code order, moving one
// jet per step, and forms E1^2-p1^2+E2^2-p2^2 with one shared squaring multiplier, eight
// squares per assignment. Each assignment squares and accumulates, then compares, then
// moves a jet (the last assignment skips the move), and a final step loads the result;
// tready stays low from the last jet of an event until that result is loaded, also for
// an error event, which goes straight to the load. Either wait stretches while an earlier
// result still waits to be taken. The lowest mask with the smallest metric wins. A
// finished result waits in an output register, and loading of the next event goes on
// meanwhile.
module hemisphere_min_mass_partition (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // jet_px, jet_py, jet_pz, jet_energy, zero pad (lowest bit first)
    input  logic [hmmp_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tlast,
    output logic                                 o_s_tready,
    // h1_px, h1_py, h1_pz, h1_energy, h2_px, h2_py, h2_pz, h2_energy, zero pad
    output logic [hmmp_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // status
    output logic [hmmp_pkg::STATUS_W-1:0]        o_m_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready
);

    hmmp_pkg::t_state  r_state;
    hmmp_pkg::t_state  n_state;

    // Jet store
    hmmp_pkg::t_jet    r_mem [hmmp_pkg::MAX_JETS];
    hmmp_pkg::t_jet    r_rd;
    hmmp_pkg::t_jet    jet_in;

    // Event bookkeeping
    logic [hmmp_pkg::CNT_W-1:0]     r_count;
    logic [hmmp_pkg::CNT_W-1:0]     cnt_new;
    logic                           r_ovf;
    hmmp_pkg::t_vec                 r_tot;
    hmmp_pkg::t_vec                 tot_add;
    hmmp_pkg::t_status              r_status;
    hmmp_pkg::t_status              ev_status;
    logic                           load_full;

    // Search state
    hmmp_pkg::t_vec                 r_h1;
    hmmp_pkg::t_vec                 h2;
    hmmp_pkg::t_vec                 sel_vec;
    hmmp_pkg::t_vec                 rd_vec;
    logic [hmmp_pkg::MAX_JETS-1:0]  r_gray;
    logic [hmmp_pkg::K_W-1:0]       r_k;
    logic [hmmp_pkg::K_W-1:0]       k_inc;
    logic [hmmp_pkg::IDX_W-1:0]     r_flip;
    logic [hmmp_pkg::IDX_W-1:0]     flip_idx;
    logic                           r_first;
    logic [hmmp_pkg::SQ_CNT_W-1:0]  r_sq_cnt;
    logic signed [hmmp_pkg::SUM_W-1:0] sq_op;
    logic signed [hmmp_pkg::MET_W-1:0] metric;
    logic signed [hmmp_pkg::MET_W-1:0] r_best;
    logic [hmmp_pkg::MAX_JETS-1:0]  r_best_mask;
    hmmp_pkg::t_vec                 r_best_h1;
    hmmp_pkg::t_vec                 best_h2;
    logic                           better;
    logic                           search_done;

    // Output register
    logic                           r_out_valid;
    logic [hmmp_pkg::OUT_DATA_W-1:0] r_out_data;
    hmmp_pkg::t_status              r_out_status;

    // Sequencer outputs
    logic                           s_accept;
    logic                           can_emit;
    logic                           emit;
    logic                           cmp_en;
    logic                           upd_en;
    hmmp_pkg::t_mac_ctl             mac_ctl;

    // Unpack the incoming jet
    always_comb begin
        jet_in.px     = i_s_tdata[hmmp_pkg::COMP_WIDTH-1:0];
        jet_in.py     = i_s_tdata[2*hmmp_pkg::COMP_WIDTH-1:hmmp_pkg::COMP_WIDTH];
        jet_in.pz     = i_s_tdata[3*hmmp_pkg::COMP_WIDTH-1:2*hmmp_pkg::COMP_WIDTH];
        jet_in.energy = i_s_tdata[4*hmmp_pkg::COMP_WIDTH-2:3*hmmp_pkg::COMP_WIDTH];
    end

    // Decide the event outcome on the closing jet
    always_comb begin
        load_full = (r_count == hmmp_pkg::CNT_W'(hmmp_pkg::MAX_JETS));
        cnt_new   = load_full ? r_count : r_count + 1'b1;
        tot_add   = hmmp_pkg::vec_add(r_tot, hmmp_pkg::jet_to_vec(jet_in));
        if (r_ovf || load_full) begin
            ev_status = hmmp_pkg::STATUS_TOO_MANY;
        end else if (cnt_new < hmmp_pkg::CNT_W'(2)) begin
            ev_status = hmmp_pkg::STATUS_TOO_FEW;
        end else begin
            ev_status = hmmp_pkg::STATUS_OK;
        end
    end

    // Pick the square operand for the current step
    always_comb begin
        h2      = hmmp_pkg::vec_sub(r_tot, r_h1);
        sel_vec = r_sq_cnt[2] ? h2 : r_h1;
        case (r_sq_cnt[1:0])
            hmmp_pkg::COMP_PX: sq_op = sel_vec.px;
            hmmp_pkg::COMP_PY: sq_op = sel_vec.py;
            hmmp_pkg::COMP_PZ: sq_op = sel_vec.pz;
            hmmp_pkg::COMP_E:  sq_op = sel_vec.energy;
            default:           sq_op = sel_vec.energy;
        endcase
    end

    hmmp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (sq_op),
        .i_ctl   (mac_ctl),
        .o_acc   (metric)
    );

    // Find the jet that moves on the next Gray-code step
    always_comb begin
        k_inc    = r_k + 1'b1;
        flip_idx = '0;
        for (int i = hmmp_pkg::MAX_JETS - 1; i >= 0; i--) begin
            if (k_inc[i]) begin
                flip_idx = hmmp_pkg::IDX_W'(i);
            end
        end
        search_done = (k_inc == (hmmp_pkg::K_W'(1) << r_count));
        better      = r_first || (metric < r_best)
                      || ((metric == r_best) && (r_gray < r_best_mask));
        rd_vec      = hmmp_pkg::jet_to_vec(r_rd);
        best_h2     = hmmp_pkg::vec_sub(r_tot, r_best_h1);
        can_emit    = !r_out_valid || i_m_tready;
    end

    // Sequencer outputs
    always_comb begin
        o_s_tready     = 1'b0;
        emit           = 1'b0;
        cmp_en         = 1'b0;
        upd_en         = 1'b0;
        mac_ctl        = '0;
        case (r_state)
            hmmp_pkg::S_LOAD: begin
                o_s_tready = 1'b1;
            end
            hmmp_pkg::S_SQ: begin
                mac_ctl.valid  = !r_sq_cnt[3];
                mac_ctl.clear  = (r_sq_cnt == '0);
                mac_ctl.negate = (r_sq_cnt[1:0] != hmmp_pkg::COMP_E);
            end
            hmmp_pkg::S_CMP: begin
                cmp_en = 1'b1;
            end
            hmmp_pkg::S_UPD: begin
                upd_en = 1'b1;
            end
            hmmp_pkg::S_OUT: begin
                emit = can_emit;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
        s_accept = o_s_tready && i_s_tvalid;
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hmmp_pkg::S_LOAD: begin
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = (ev_status == hmmp_pkg::STATUS_OK) ? hmmp_pkg::S_SQ
                                                                 : hmmp_pkg::S_OUT;
                end
            end
            hmmp_pkg::S_SQ: begin
                if (r_sq_cnt == hmmp_pkg::SQ_CNT_W'(hmmp_pkg::NUM_SQ)) begin
                    n_state = hmmp_pkg::S_CMP;
                end
            end
            hmmp_pkg::S_CMP: begin
                n_state = search_done ? hmmp_pkg::S_OUT : hmmp_pkg::S_UPD;
            end
            hmmp_pkg::S_UPD: begin
                n_state = hmmp_pkg::S_SQ;
            end
            hmmp_pkg::S_OUT: begin
                if (can_emit) begin
                    n_state = hmmp_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = hmmp_pkg::S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hmmp_pkg::S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_tot       <= '0;
            r_sq_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Gather jets, drop the ones beyond the store
            if (s_accept) begin
                r_count <= cnt_new;
                if (load_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_tot <= tot_add;
                end
            end else if (emit) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_tot   <= '0;
            end
            // Step through the eight squares
            if (r_state == hmmp_pkg::S_SQ) begin
                r_sq_cnt <= r_sq_cnt + 1'b1;
            end else begin
                r_sq_cnt <= '0;
            end
            // Hold the result until taken
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Jet store: write on load, registered read of the jet that moves next
    always_ff @(posedge i_clk) begin
        if (s_accept && !load_full) begin
            r_mem[r_count[hmmp_pkg::IDX_W-1:0]] <= jet_in;
        end
        r_rd <= r_mem[flip_idx];
    end

    // Search datapath
    always_ff @(posedge i_clk) begin
        if (s_accept && i_s_tlast) begin
            r_status <= ev_status;
            r_h1     <= tot_add;
            r_gray   <= '0;
            r_k      <= '0;
            r_first  <= 1'b1;
        end
        if (cmp_en) begin
            r_first <= 1'b0;
            r_flip  <= flip_idx;
            if (better) begin
                r_best      <= metric;
                r_best_mask <= r_gray;
                r_best_h1   <= r_h1;
            end
        end
        // Move one jet between hemispheres
        if (upd_en) begin
            r_gray[r_flip] <= !r_gray[r_flip];
            r_k            <= k_inc;
            if (!r_gray[r_flip]) begin
                r_h1 <= hmmp_pkg::vec_sub(r_h1, rd_vec);
            end else begin
                r_h1 <= hmmp_pkg::vec_add(r_h1, rd_vec);
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_status <= r_status;
            if (r_status == hmmp_pkg::STATUS_OK) begin
                r_out_data <= {{hmmp_pkg::OUT_PAD_W{1'b0}},
                               best_h2.energy[hmmp_pkg::E_OUT_W-1:0],
                               best_h2.pz[hmmp_pkg::P_OUT_W-1:0],
                               best_h2.py[hmmp_pkg::P_OUT_W-1:0],
                               best_h2.px[hmmp_pkg::P_OUT_W-1:0],
                               r_best_h1.energy[hmmp_pkg::E_OUT_W-1:0],
                               r_best_h1.pz[hmmp_pkg::P_OUT_W-1:0],
                               r_best_h1.py[hmmp_pkg::P_OUT_W-1:0],
                               r_best_h1.px[hmmp_pkg::P_OUT_W-1:0]};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

endmodule

// ===== bench/hemisphere_min_mass_partition_tb.sv =====
// Self-checking testbench for the hemisphere minimum-mass partition block.
`timescale 1ns / 1ps

module hemisphere_min_mass_partition_tb;

    localparam int WATCHDOG_LIMIT = 3_000_000;
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_ITEMS   = 450;
    localparam int HOLD_CYCLES    = 3000;
    localparam int MAX_PRINTED    = 50;
    localparam int CW             = hmmp_pkg::COMP_WIDTH;
    localparam int PW             = hmmp_pkg::P_OUT_W;
    localparam int EW             = hmmp_pkg::E_OUT_W;

    localparam logic [CW-1:0] P_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] P_MAX = ~P_MIN;
    localparam logic [CW-2:0] E_MAX = '1;

    // Output tdata layout, first field in the lowest bits
    typedef struct packed {
        logic [hmmp_pkg::OUT_PAD_W-1:0] pad;
        logic [EW-1:0]   h2_energy;
        logic [PW-1:0]   h2_pz;
        logic [PW-1:0]   h2_py;
        logic [PW-1:0]   h2_px;
        logic [EW-1:0]   h1_energy;
        logic [PW-1:0]   h1_pz;
        logic [PW-1:0]   h1_py;
        logic [PW-1:0]   h1_px;
    } t_hemi_pair;

    typedef struct packed {
        hmmp_pkg::t_status status;
        t_hemi_pair        sums;
    } t_hemi_result;

    logic                                i_clk      = 1'b0;
    logic                                i_rst_n    = 1'b0;
    logic [hmmp_pkg::IN_DATA_W-1:0]      i_s_tdata  = '0;
    logic                                i_s_tvalid = 1'b0;
    logic                                i_s_tlast  = 1'b0;
    logic                                o_s_tready;
    logic [hmmp_pkg::OUT_DATA_W-1:0]     o_m_tdata;
    logic [hmmp_pkg::STATUS_W-1:0]       o_m_tuser;
    logic                                o_m_tvalid;
    logic                                i_m_tready = 1'b0;

    // Event state of the predictor
    longint       jet_store [hmmp_pkg::MAX_JETS][4];
    int           jets_held       = 0;
    bit           event_overflow  = 1'b0;
    t_hemi_result expected_sums [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int stall_cycles   = 0;
    int hold_requests  = 0;
    int hold_len       = 0;
    bit sender_quiet   = 1'b0;

    hemisphere_min_mass_partition dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [PW-1:0] got,
                               input logic [PW-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    task automatic compare_sums(input t_hemi_result got, input t_hemi_result want);
        check_field("status", PW'(got.status), PW'(want.status));
        check_field("h1_px", got.sums.h1_px, want.sums.h1_px);
        check_field("h1_py", got.sums.h1_py, want.sums.h1_py);
        check_field("h1_pz", got.sums.h1_pz, want.sums.h1_pz);
        check_field("h1_energy", PW'(got.sums.h1_energy), PW'(want.sums.h1_energy));
        check_field("h2_px", got.sums.h2_px, want.sums.h2_px);
        check_field("h2_py", got.sums.h2_py, want.sums.h2_py);
        check_field("h2_pz", got.sums.h2_pz, want.sums.h2_pz);
        check_field("h2_energy", PW'(got.sums.h2_energy), PW'(want.sums.h2_energy));
    endtask

    function automatic longint inv_mass_sq(longint e, longint x, longint y, longint z);
        return e * e - x * x - y * y - z * z;
    endfunction

    // Search every mask over the held jets; the first strictly smallest metric wins
    function automatic t_hemi_result best_partition();
        t_hemi_result r;
        longint       tot [4];
        longint       h2 [4];
        longint       met;
        longint       best_met;
        int           best;
        r        = '0;
        best     = 0;
        best_met = 0;
        for (int k = 0; k < 4; k++) begin
            tot[k] = 0;
            for (int i = 0; i < jets_held; i++) begin
                tot[k] += jet_store[i][k];
            end
        end
        for (int m = 0; m < (1 << jets_held); m++) begin
            for (int k = 0; k < 4; k++) begin
                h2[k] = 0;
            end
            for (int i = 0; i < jets_held; i++) begin
                if (((m >> i) & 1) != 0) begin
                    for (int k = 0; k < 4; k++) begin
                        h2[k] += jet_store[i][k];
                    end
                end
            end
            met = inv_mass_sq(tot[hmmp_pkg::COMP_E] - h2[hmmp_pkg::COMP_E],
                              tot[hmmp_pkg::COMP_PX] - h2[hmmp_pkg::COMP_PX],
                              tot[hmmp_pkg::COMP_PY] - h2[hmmp_pkg::COMP_PY],
                              tot[hmmp_pkg::COMP_PZ] - h2[hmmp_pkg::COMP_PZ])
                + inv_mass_sq(h2[hmmp_pkg::COMP_E], h2[hmmp_pkg::COMP_PX],
                              h2[hmmp_pkg::COMP_PY], h2[hmmp_pkg::COMP_PZ]);
            if (m == 0 || met < best_met) begin
                best_met = met;
                best     = m;
            end
        end
        // Rebuild the sums of the winning mask
        for (int k = 0; k < 4; k++) begin
            h2[k] = 0;
        end
        for (int i = 0; i < jets_held; i++) begin
            if (((best >> i) & 1) != 0) begin
                for (int k = 0; k < 4; k++) begin
                    h2[k] += jet_store[i][k];
                end
            end
        end
        r.status         = hmmp_pkg::STATUS_OK;
        r.sums.h1_px     = PW'(tot[hmmp_pkg::COMP_PX] - h2[hmmp_pkg::COMP_PX]);
        r.sums.h1_py     = PW'(tot[hmmp_pkg::COMP_PY] - h2[hmmp_pkg::COMP_PY]);
        r.sums.h1_pz     = PW'(tot[hmmp_pkg::COMP_PZ] - h2[hmmp_pkg::COMP_PZ]);
        r.sums.h1_energy = EW'(tot[hmmp_pkg::COMP_E] - h2[hmmp_pkg::COMP_E]);
        r.sums.h2_px     = PW'(h2[hmmp_pkg::COMP_PX]);
        r.sums.h2_py     = PW'(h2[hmmp_pkg::COMP_PY]);
        r.sums.h2_pz     = PW'(h2[hmmp_pkg::COMP_PZ]);
        r.sums.h2_energy = EW'(h2[hmmp_pkg::COMP_E]);
        return r;
    endfunction

    // Hold one accepted jet; on the last jet queue the expected event result
    function automatic void absorb_jet(hmmp_pkg::t_jet j, bit last);
        t_hemi_result r;
        if (jets_held < hmmp_pkg::MAX_JETS) begin
            jet_store[jets_held][hmmp_pkg::COMP_PX] = longint'($signed(j.px));
            jet_store[jets_held][hmmp_pkg::COMP_PY] = longint'($signed(j.py));
            jet_store[jets_held][hmmp_pkg::COMP_PZ] = longint'($signed(j.pz));
            jet_store[jets_held][hmmp_pkg::COMP_E]  = longint'(j.energy);
            jets_held++;
        end else begin
            event_overflow = 1'b1;
        end
        if (!last) begin
            return;
        end
        r = '0;
        if (event_overflow) begin
            r.status = hmmp_pkg::STATUS_TOO_MANY;
        end else if (jets_held < 2) begin
            r.status = hmmp_pkg::STATUS_TOO_FEW;
        end else begin
            r = best_partition();
        end
        expected_sums.push_back(r);
        jets_held      = 0;
        event_overflow = 1'b0;
    endfunction

    // Predict on every accepted request
    always @(posedge i_clk) begin : take_jet
        hmmp_pkg::t_jet j;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            j.px     = i_s_tdata[0 +: CW];
            j.py     = i_s_tdata[CW +: CW];
            j.pz     = i_s_tdata[2*CW +: CW];
            j.energy = i_s_tdata[3*CW +: CW-1];
            absorb_jet(j, i_s_tlast);
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge i_clk) begin : take_result
        t_hemi_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = hmmp_pkg::t_status'(o_m_tuser);
            got.sums   = o_m_tdata;
            if (expected_sums.size() == 0) begin
                report_mismatch("result with no event pending");
            end else begin
                compare_sums(got, expected_sums.pop_front());
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Mostly short idle stretches, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end
        if (r < 93) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 120);
    endfunction

    // Receiver: random stalls, ready bursts and requested long hold-offs
    initial begin : receiver
        int stall_left;
        int burst_left;
        int hold_left;
        int holds_served;
        stall_left   = 0;
        burst_left   = 0;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                i_m_tready <= 1'b1;
            end else if ($urandom_range(0, 9) < 2) begin
                burst_left = $urandom_range(30, 150);
                i_m_tready <= 1'b1;
            end else if ($urandom_range(0, 9) < 3) begin
                stall_left = idle_len() - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic hmmp_pkg::t_jet make_jet(logic [CW-1:0] px, logic [CW-1:0] py,
                                                logic [CW-1:0] pz, logic [CW-2:0] e);
        hmmp_pkg::t_jet j;
        j.px     = px;
        j.py     = py;
        j.pz     = pz;
        j.energy = e;
        return j;
    endfunction

    // Mix of extremes, small values and the full range
    function automatic logic [CW-1:0] random_momentum();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return P_MIN;
        end
        if (r == 1) begin
            return P_MAX;
        end
        if (r == 2) begin
            return '0;
        end
        if (r < 5) begin
            return CW'($urandom_range(0, 128) - 64);
        end
        return CW'($urandom());
    endfunction

    function automatic logic [CW-2:0] random_energy();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return E_MAX;
        end
        if (r == 1) begin
            return '0;
        end
        if (r < 4) begin
            return (CW-1)'($urandom_range(0, 128));
        end
        return (CW-1)'($urandom());
    endfunction

    function automatic hmmp_pkg::t_jet random_jet();
        return make_jet(random_momentum(), random_momentum(), random_momentum(),
                        random_energy());
    endfunction

    // Offer one jet, optionally after an idle gap, and wait until it is taken
    task automatic send_jet(input hmmp_pkg::t_jet j, input bit last);
        int gap;
        gap = (sender_quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= hmmp_pkg::IN_DATA_W'({j.energy, j.pz, j.py, j.px});
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    task automatic send_event(input int n);
        for (int i = 0; i < n; i++) begin
            send_jet(random_jet(), i == n - 1);
        end
    endtask

    // Stop offering and wait for every pending result
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_sums.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_too_few();
        send_jet(make_jet(P_MIN, P_MAX, '0, E_MAX), 1'b1);
    endtask

    task automatic test_field_extremes();
        send_jet(make_jet(P_MIN, P_MAX, P_MIN, E_MAX), 1'b0);
        send_jet(make_jet(P_MAX, P_MIN, P_MAX, '0), 1'b1);
        send_jet(make_jet(P_MAX, P_MAX, P_MAX, E_MAX), 1'b0);
        send_jet(make_jet(P_MIN, P_MIN, P_MIN, E_MAX), 1'b1);
    endtask

    // Equal metrics: the lowest mask must win
    task automatic test_ties();
        send_jet(make_jet('0, '0, '0, '0), 1'b0);
        send_jet(make_jet('0, '0, '0, '0), 1'b0);
        send_jet(make_jet('0, '0, '0, '0), 1'b1);
        send_jet(make_jet(CW'(100), -CW'(50), CW'(25), 19'd300), 1'b0);
        send_jet(make_jet(CW'(100), -CW'(50), CW'(25), 19'd300), 1'b1);
    endtask

    // One jet over capacity, then a normal event to see the counters cleared
    task automatic test_overflow();
        send_event(hmmp_pkg::MAX_JETS + 1);
        send_event(2);
    endtask

    task automatic test_full_event();
        send_event(hmmp_pkg::MAX_JETS);
    endtask

    // Hold the output off while events keep coming, then pause until drained
    task automatic test_output_backpressure();
        wait_drained();
        hold_len = HOLD_CYCLES;
        hold_requests++;
        sender_quiet = 1'b1;
        repeat (6) send_event($urandom_range(2, 3));
        sender_quiet = 1'b0;
        wait_drained();
    endtask

    // Mostly well-formed events of modest size, some too short or too long
    task automatic test_random_events();
        int start;
        int r;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            sender_quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_event(1);
            end else if (r < 15) begin
                send_event($urandom_range(hmmp_pkg::MAX_JETS + 1, hmmp_pkg::MAX_JETS + 3));
            end else if (r < 30) begin
                send_event($urandom_range(7, 9));
            end else begin
                send_event($urandom_range(2, 6));
            end
        end
        sender_quiet = 1'b0;
    endtask

    initial begin : run
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_too_few();
        test_field_extremes();
        test_ties();
        test_overflow();
        test_full_event();
        test_output_backpressure();
        test_random_events();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_sums.size() != 0) begin
            report_mismatch("expected results never arrived");
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
